FILE: src/bsmc_pkg.sv
package bsmc_pkg;

  // switch mode codes
  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_CHG    = 2'd1,
    MODE_DIS    = 2'd2,
    MODE_NORMAL = 2'd3
  } bsmc_mode_t;

  // field widths
  localparam int ERR_W  = 14;
  localparam int CUR_W  = 18;
  localparam int THR_W  = 16;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 16;
  localparam int IN_DW  = 40;
  localparam int OUT_DW = 8;

  // chg off flag never blocks either direction
  localparam int CHG_OFF_BIT = 12;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_CHG_EN   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DIS_EN   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CHG_MASK = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DIS_MASK = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DIODE_ON  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_DIODE_OFF = 3'd5;

  // register reset values
  localparam logic [ERR_W-1:0] CHG_MASK_RST  = 14'd3889;
  localparam logic [ERR_W-1:0] DIS_MASK_RST  = 14'd11502;
  localparam logic [THR_W-1:0] DIODE_ON_RST  = 16'd500;
  localparam logic [THR_W-1:0] DIODE_OFF_RST = 16'd100;

  typedef struct packed {
    logic [ERR_W-1:0]        error_bits;
    logic                    pack_full;
    logic                    pack_empty;
    logic                    startup_hold;
    logic signed [CUR_W-1:0] pack_current_ma;
  } bsmc_item_t;

  typedef struct packed {
    logic             charge_enable;
    logic             discharge_enable;
    logic [ERR_W-1:0] charge_error_mask;
    logic [ERR_W-1:0] discharge_error_mask;
    logic [THR_W-1:0] diode_on_current_ma;
    logic [THR_W-1:0] diode_off_current_ma;
  } bsmc_cfg_t;

  typedef struct packed {
    bsmc_mode_t mode;
    logic       charge_switch_on;
    logic       discharge_switch_on;
  } bsmc_state_t;

endpackage

FILE: src/battery_switch_mode_controller_unit.sv
// channel   dir  fields (lsb first)
// s_axis    in   tdata: error_bits[13:0] pack_full[14] pack_empty[15] startup_hold[16]
//                       pack_current_ma[34:17], zero fill to 40 bits
// m_axis    out  tdata: mode[1:0] charge_switch_on[2] discharge_switch_on[3], zero fill
// cfg       in   cfg_we, cfg_addr (register index), cfg_wdata
//
// one item per cycle sustained while results are taken; an input passes the input
// register, then one pass of the mode update into the state register
// the state register doubles as the result register, so a result stall
// holds the update and the input register back-pressures s_tready
// rst is synchronous, active high: mode off, both switches open,
// registers back to their defaults
module battery_switch_mode_controller_unit (
  input  logic                          clk,
  input  logic                          rst,
  // error_bits, pack_full, pack_empty, startup_hold, pack_current_ma
  input  logic [bsmc_pkg::IN_DW-1:0]    s_tdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // mode, charge_switch_on, discharge_switch_on
  output logic [bsmc_pkg::OUT_DW-1:0]   m_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                          cfg_we,
  input  logic [bsmc_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [bsmc_pkg::CFG_DW-1:0]   cfg_wdata
);
  import bsmc_pkg::*;

  localparam int ITEM_W = ERR_W + 3 + CUR_W;

  bsmc_cfg_t   cfg;
  bsmc_item_t  in_item;
  logic        in_valid;
  bsmc_state_t state;
  bsmc_state_t state_next;
  logic        out_valid;
  logic        out_free;
  logic        advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.charge_enable        <= 1'b1;
      cfg.discharge_enable     <= 1'b1;
      cfg.charge_error_mask    <= CHG_MASK_RST;
      cfg.discharge_error_mask <= DIS_MASK_RST;
      cfg.diode_on_current_ma  <= DIODE_ON_RST;
      cfg.diode_off_current_ma <= DIODE_OFF_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CHG_EN:    cfg.charge_enable        <= cfg_wdata[0];
        REG_DIS_EN:    cfg.discharge_enable     <= cfg_wdata[0];
        REG_CHG_MASK:  cfg.charge_error_mask    <= cfg_wdata[ERR_W-1:0];
        REG_DIS_MASK:  cfg.discharge_error_mask <= cfg_wdata[ERR_W-1:0];
        REG_DIODE_ON:  cfg.diode_on_current_ma  <= cfg_wdata[THR_W-1:0];
        REG_DIODE_OFF: cfg.diode_off_current_ma <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.error_bits      <= s_tdata[ERR_W-1:0];
      in_item.pack_full       <= s_tdata[ERR_W];
      in_item.pack_empty      <= s_tdata[ERR_W+1];
      in_item.startup_hold    <= s_tdata[ERR_W+2];
      in_item.pack_current_ma <= signed'(s_tdata[ITEM_W-1:ERR_W+3]);
    end
  end

  bsmc_step u_step (
    .item (in_item),
    .cfg  (cfg),
    .cur  (state),
    .nxt  (state_next)
  );

  // state register, also the result held for the output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode                <= MODE_OFF;
      state.charge_switch_on    <= 1'b0;
      state.discharge_switch_on <= 1'b0;
      out_valid                 <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (out_free) begin
        out_valid <= advance;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DW-4){1'b0}}, state.discharge_switch_on,
                     state.charge_switch_on, state.mode};

endmodule

FILE: src/bsmc_step.sv
module bsmc_step (
  input  bsmc_pkg::bsmc_item_t  item,
  input  bsmc_pkg::bsmc_cfg_t   cfg,
  input  bsmc_pkg::bsmc_state_t cur,
  output bsmc_pkg::bsmc_state_t nxt
);
  import bsmc_pkg::*;

  localparam int CMP_W = CUR_W + 1;

  logic [ERR_W-1:0]        err_eff;
  logic                    chg_ok;
  logic                    dis_ok;
  logic signed [CMP_W-1:0] cur_x;
  logic signed [CMP_W-1:0] on_x;
  logic signed [CMP_W-1:0] off_x;

  // permission checks, chg off flag stripped first
  always_comb begin
    err_eff = item.error_bits;
    err_eff[CHG_OFF_BIT] = 1'b0;
    chg_ok = ((err_eff & cfg.charge_error_mask) == '0) && !item.pack_full
             && cfg.charge_enable;
    dis_ok = ((err_eff & cfg.discharge_error_mask) == '0) && !item.pack_empty
             && cfg.discharge_enable;
  end

  // widened operands for the diode hysteresis compares
  assign cur_x = CMP_W'(item.pack_current_ma);
  assign on_x  = signed'({{(CMP_W-THR_W){1'b0}}, cfg.diode_on_current_ma});
  assign off_x = signed'({{(CMP_W-THR_W){1'b0}}, cfg.diode_off_current_ma});

  // mode transitions
  always_comb begin
    nxt = cur;
    case (cur.mode)
      MODE_OFF: begin
        if (!item.startup_hold) begin
          if (dis_ok) begin
            nxt.discharge_switch_on = 1'b1;
            nxt.mode = MODE_DIS;
          end else if (chg_ok) begin
            nxt.charge_switch_on = 1'b1;
            nxt.mode = MODE_CHG;
          end
        end
      end
      MODE_CHG: begin
        if (!chg_ok) begin
          nxt.charge_switch_on = 1'b0;
          nxt.discharge_switch_on = 1'b0;
          nxt.mode = MODE_OFF;
        end else if (dis_ok) begin
          nxt.discharge_switch_on = 1'b1;
          nxt.mode = MODE_NORMAL;
        end else if (cur_x > on_x) begin
          nxt.discharge_switch_on = 1'b1;
        end else if (cur_x < off_x) begin
          nxt.discharge_switch_on = 1'b0;
        end
      end
      MODE_DIS: begin
        if (!dis_ok) begin
          nxt.charge_switch_on = 1'b0;
          nxt.discharge_switch_on = 1'b0;
          nxt.mode = MODE_OFF;
        end else if (chg_ok) begin
          nxt.charge_switch_on = 1'b1;
          nxt.mode = MODE_NORMAL;
        end else if (cur_x < -on_x) begin
          nxt.charge_switch_on = 1'b1;
        end else if (cur_x > -off_x) begin
          nxt.charge_switch_on = 1'b0;
        end
      end
      MODE_NORMAL: begin
        if (!dis_ok) begin
          nxt.discharge_switch_on = 1'b0;
          nxt.mode = MODE_CHG;
        end else if (!chg_ok) begin
          nxt.charge_switch_on = 1'b0;
          nxt.mode = MODE_DIS;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

FILE: src/bsmc_checker.sv
module bsmc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic [bsmc_pkg::OUT_DW-1:0] m_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready
);
  import bsmc_pkg::*;

  logic [1:0] mode_o;
  logic       chg_o;
  logic       dis_o;

  assign mode_o = m_tdata[1:0];
  assign chg_o  = m_tdata[2];
  assign dis_o  = m_tdata[3];

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // off mode keeps both switches open
  a_off_open: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && mode_o == MODE_OFF |-> !chg_o && !dis_o)
    else $error("switch closed in off mode");

  // each active mode keeps its own switch closed
  a_mode_switch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (mode_o != MODE_CHG || chg_o) && (mode_o != MODE_DIS || dis_o)
                 && (mode_o != MODE_NORMAL || (chg_o && dis_o)))
    else $error("mode and switch states disagree");

endmodule

bind battery_switch_mode_controller_unit bsmc_checker u_bsmc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
